### hdl/ssl_pkg.sv
package ssl_pkg;

  // Lexer modes
  typedef enum logic [3:0] {
    M_IDLE,
    M_IDENT,
    M_ZERO,
    M_OCT,
    M_ZX,
    M_HEX,
    M_ZB,
    M_BIN,
    M_DEC,
    M_SLASH,
    M_LINE,
    M_BLOCK,
    M_BSTAR,
    M_OP
  } mode_t;

  // Result kinds
  localparam logic [1:0] K_TOKEN = 2'd0;
  localparam logic [1:0] K_ERROR = 2'd1;
  localparam logic [1:0] K_END   = 2'd2;

  // Token types
  localparam logic [5:0] T_IDENT = 6'd0;
  localparam logic [5:0] T_BIN   = 6'd16;
  localparam logic [5:0] T_OCT   = 6'd17;
  localparam logic [5:0] T_DEC   = 6'd18;
  localparam logic [5:0] T_HEX   = 6'd19;
  localparam logic [5:0] T_LINE  = 6'd20;
  localparam logic [5:0] T_BLOCK = 6'd21;
  localparam logic [5:0] T_DIV   = 6'd33;

  localparam logic [4:0] TAB_RESET = 5'd4;

  function automatic logic is_letter(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a) || c == 8'h5f;
  endfunction

  function automatic logic is_dec(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic is_oct(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h37;
  endfunction

  function automatic logic is_bin(input logic [7:0] c);
    return c == 8'h30 || c == 8'h31;
  endfunction

  function automatic logic is_hex(input logic [7:0] c);
    return is_dec(c) || (c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46);
  endfunction

  function automatic logic may_pair(input logic [7:0] c);
    return c == 8'h3d || c == 8'h2d || c == 8'h3c || c == 8'h3e || c == 8'h26 ||
           c == 8'h7c || c == 8'h21;
  endfunction

  function automatic logic [5:0] one_char_op(input logic [7:0] c);
    logic [5:0] t;
    case (c)
      8'h28: t = 6'd22;
      8'h29: t = 6'd23;
      8'h7b: t = 6'd24;
      8'h7d: t = 6'd25;
      8'h3d: t = 6'd26;
      8'h2b: t = 6'd29;
      8'h2d: t = 6'd30;
      8'h2a: t = 6'd32;
      8'h2f: t = 6'd33;
      8'h25: t = 6'd34;
      8'h3c: t = 6'd35;
      8'h3e: t = 6'd38;
      8'h26: t = 6'd41;
      8'h7c: t = 6'd43;
      8'h5e: t = 6'd45;
      8'h7e: t = 6'd46;
      8'h21: t = 6'd47;
      8'h3a: t = 6'd49;
      8'h3b: t = 6'd50;
      8'h2e: t = 6'd51;
      8'h2c: t = 6'd52;
      default: t = 6'd0;
    endcase
    return t;
  endfunction

  function automatic logic [5:0] two_char_op(input logic [7:0] a, input logic [7:0] b);
    logic [5:0] t;
    t = 6'd0;
    if (a == 8'h3d && b == 8'h3d) t = 6'd27;
    if (a == 8'h3d && b == 8'h3e) t = 6'd28;
    if (a == 8'h2d && b == 8'h3e) t = 6'd31;
    if (a == 8'h3c && b == 8'h3c) t = 6'd36;
    if (a == 8'h3c && b == 8'h3d) t = 6'd37;
    if (a == 8'h3e && b == 8'h3e) t = 6'd39;
    if (a == 8'h3e && b == 8'h3d) t = 6'd40;
    if (a == 8'h26 && b == 8'h26) t = 6'd42;
    if (a == 8'h7c && b == 8'h7c) t = 6'd44;
    if (a == 8'h21 && b == 8'h3d) t = 6'd48;
    return t;
  endfunction

  // Keyword lookup; buffer holds the first bytes little end first, zero above
  function automatic logic [5:0] keyword_code(input logic [63:0] w, input logic [3:0] n);
    logic [5:0] t;
    t = T_IDENT;
    if (n == 4'd2 && w == 64'h6669) t = 6'd1;
    if (n == 4'd4 && w == 64'h65736c65) t = 6'd2;
    if (n == 4'd3 && w == 64'h726f66) t = 6'd3;
    if (n == 4'd3 && w == 64'h74656c) t = 6'd4;
    if (n == 4'd5 && w == 64'h74736e6f63) t = 6'd5;
    if (n == 4'd3 && w == 64'h746e49) t = 6'd6;
    if (n == 4'd4 && w == 64'h746e6955) t = 6'd7;
    if (n == 4'd4 && w == 64'h6c6f6f42) t = 6'd8;
    if (n == 4'd5 && w == 64'h6b61657262) t = 6'd9;
    if (n == 4'd8 && w == 64'h65756e69746e6f63) t = 6'd10;
    if (n == 4'd6 && w == 64'h6e7275746572) t = 6'd11;
    if (n == 4'd8 && w == 64'h6e6f6974636e7566) t = 6'd12;
    if (n == 4'd4 && w == 64'h65757274) t = 6'd13;
    if (n == 4'd5 && w == 64'h65736c6166) t = 6'd14;
    if (n == 4'd8 && w == 64'h7365726975716572) t = 6'd15;
    return t;
  endfunction

endpackage

### hdl/ssl_in_if.sv
interface ssl_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_byte;
  logic       last_byte;

  modport source (output valid, output char_byte, output last_byte, input ready);
  modport sink (input valid, input char_byte, input last_byte, output ready);
endinterface

### hdl/ssl_out_if.sv
interface ssl_out_if #(
  parameter int OFFSET_BITS = 24,
  parameter int LINE_BITS   = 20,
  parameter int LENGTH_BITS = 16
);
  logic                   valid;
  logic                   ready;
  logic [1:0]             kind;
  logic [5:0]             tok_code;
  logic [OFFSET_BITS-1:0] start_offset;
  logic [LINE_BITS-1:0]   start_line;
  logic [LINE_BITS-1:0]   start_column;
  logic [LENGTH_BITS-1:0] token_length;
  logic                   stream_end;

  modport source (output valid, output kind, output tok_code, output start_offset,
                  output start_line, output start_column, output token_length,
                  output stream_end, input ready);
  modport sink (input valid, input kind, input tok_code, input start_offset,
                input start_line, input start_column, input token_length,
                input stream_end, output ready);
endinterface

### hdl/ssl_core.sv
module ssl_core #(
  parameter int OFFSET_BITS = 24,
  parameter int LINE_BITS   = 20,
  parameter int LENGTH_BITS = 16,
  localparam int RES_W      = 2 + 6 + OFFSET_BITS + 2 * LINE_BITS + LENGTH_BITS + 1,
  localparam int PAIR_W     = 2 + 2 * RES_W
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_write_en,
  input  logic [4:0]        cfg_write_data,
  input  logic              accept,
  input  logic [7:0]        char_byte,
  input  logic              last_byte,
  output logic [PAIR_W-1:0] pair_bits
);

  typedef struct packed {
    logic [1:0]             kind;
    logic [5:0]             tok_code;
    logic [OFFSET_BITS-1:0] start_offset;
    logic [LINE_BITS-1:0]   start_line;
    logic [LINE_BITS-1:0]   start_column;
    logic [LENGTH_BITS-1:0] token_length;
    logic                   stream_end;
  } res_t;

  typedef struct packed {
    logic [1:0] n;
    res_t       r1;
    res_t       r0;
  } pair_t;

  function automatic res_t mk(input logic [1:0] k, input logic [5:0] t,
                              input logic [OFFSET_BITS-1:0] o,
                              input logic [LINE_BITS-1:0] l,
                              input logic [LINE_BITS-1:0] c,
                              input logic [LENGTH_BITS-1:0] n);
    res_t r;
    r.kind = k;
    r.tok_code = t;
    r.start_offset = o;
    r.start_line = l;
    r.start_column = c;
    r.token_length = n;
    r.stream_end = 1'b0;
    return r;
  endfunction

  function automatic pair_t push(input pair_t p, input res_t r);
    pair_t q;
    q = p;
    if (p.n == 2'd0) q.r0 = r;
    else q.r1 = r;
    q.n = p.n + 2'd1;
    return q;
  endfunction

  logic [4:0]             tab_width;
  ssl_pkg::mode_t         mode, mode_next;
  logic [63:0]            wbuf, wbuf_next;
  logic [3:0]             wcnt, wcnt_next;
  logic [OFFSET_BITS-1:0] toff, toff_next, coff, coff_next, coff_inc;
  logic [LINE_BITS-1:0]   tline, tline_next, tcol, tcol_next;
  logic [LINE_BITS-1:0]   cline, cline_next, ccol, ccol_next, ccol_inc, cline_inc;
  logic [LINE_BITS:0]     ccol_tab;
  logic [LENGTH_BITS-1:0] tlen, tlen_next, tlen_inc;
  logic                   halted, halted_next;
  logic                   used;
  logic [5:0]             pair_op;
  pair_t                  pr;

  // Saturating increments of the current state
  assign coff_inc  = (&coff) ? coff : coff + 1'b1;
  assign ccol_inc  = (&ccol) ? ccol : ccol + 1'b1;
  assign cline_inc = (&cline) ? cline : cline + 1'b1;
  assign tlen_inc  = (&tlen) ? tlen : tlen + 1'b1;
  assign ccol_tab  = {1'b0, ccol} + {{(LINE_BITS - 4){1'b0}}, tab_width};
  assign pair_op   = ssl_pkg::two_char_op(wbuf[7:0], char_byte);

  // Work out one byte: extend, start, close, end of source
  always_comb begin
    mode_next = mode;
    wbuf_next = wbuf;
    wcnt_next = wcnt;
    toff_next = toff;
    tline_next = tline;
    tcol_next = tcol;
    tlen_next = tlen;
    coff_next = coff;
    cline_next = cline;
    ccol_next = ccol;
    halted_next = halted;
    used = 1'b0;
    pr = '0;

    if (!halted) begin
      // Extend the pending token
      case (mode)
        ssl_pkg::M_IDLE: used = 1'b0;
        ssl_pkg::M_IDENT: begin
          if (ssl_pkg::is_letter(char_byte) || ssl_pkg::is_dec(char_byte)) begin
            if (wcnt < 4'd8) begin
              wbuf_next = wbuf | ({56'd0, char_byte} << {wcnt[2:0], 3'b000});
              wcnt_next = wcnt + 4'd1;
            end else begin
              wcnt_next = 4'd9;
            end
            used = 1'b1;
          end else begin
            pr = push(pr, mk(ssl_pkg::K_TOKEN, ssl_pkg::keyword_code(wbuf, wcnt),
                             toff, tline, tcol, tlen));
            mode_next = ssl_pkg::M_IDLE;
          end
        end
        ssl_pkg::M_ZERO: begin
          if (char_byte == 8'h78) begin
            used = 1'b1;
            mode_next = ssl_pkg::M_ZX;
          end else if (char_byte == 8'h62) begin
            used = 1'b1;
            mode_next = ssl_pkg::M_ZB;
          end else if (ssl_pkg::is_oct(char_byte)) begin
            used = 1'b1;
            mode_next = ssl_pkg::M_OCT;
          end else begin
            pr = push(pr, mk(ssl_pkg::K_TOKEN, ssl_pkg::T_OCT, toff, tline, tcol, tlen));
            mode_next = ssl_pkg::M_IDLE;
          end
        end
        ssl_pkg::M_OCT: begin
          if (ssl_pkg::is_oct(char_byte)) used = 1'b1;
          else begin
            pr = push(pr, mk(ssl_pkg::K_TOKEN, ssl_pkg::T_OCT, toff, tline, tcol, tlen));
            mode_next = ssl_pkg::M_IDLE;
          end
        end
        ssl_pkg::M_ZX: begin
          if (ssl_pkg::is_hex(char_byte)) begin
            used = 1'b1;
            mode_next = ssl_pkg::M_HEX;
          end else begin
            pr = push(pr, mk(ssl_pkg::K_ERROR, ssl_pkg::T_IDENT, toff, tline, tcol, '0));
            halted_next = 1'b1;
            mode_next = ssl_pkg::M_IDLE;
          end
        end
        ssl_pkg::M_ZB: begin
          if (ssl_pkg::is_bin(char_byte)) begin
            used = 1'b1;
            mode_next = ssl_pkg::M_BIN;
          end else begin
            pr = push(pr, mk(ssl_pkg::K_ERROR, ssl_pkg::T_IDENT, toff, tline, tcol, '0));
            halted_next = 1'b1;
            mode_next = ssl_pkg::M_IDLE;
          end
        end
        ssl_pkg::M_HEX: begin
          if (ssl_pkg::is_hex(char_byte)) used = 1'b1;
          else begin
            pr = push(pr, mk(ssl_pkg::K_TOKEN, ssl_pkg::T_HEX, toff, tline, tcol, tlen));
            mode_next = ssl_pkg::M_IDLE;
          end
        end
        ssl_pkg::M_BIN: begin
          if (ssl_pkg::is_bin(char_byte)) used = 1'b1;
          else begin
            pr = push(pr, mk(ssl_pkg::K_TOKEN, ssl_pkg::T_BIN, toff, tline, tcol, tlen));
            mode_next = ssl_pkg::M_IDLE;
          end
        end
        ssl_pkg::M_DEC: begin
          if (ssl_pkg::is_dec(char_byte)) used = 1'b1;
          else begin
            pr = push(pr, mk(ssl_pkg::K_TOKEN, ssl_pkg::T_DEC, toff, tline, tcol, tlen));
            mode_next = ssl_pkg::M_IDLE;
          end
        end
        ssl_pkg::M_SLASH: begin
          if (char_byte == 8'h2f) begin
            used = 1'b1;
            mode_next = ssl_pkg::M_LINE;
          end else if (char_byte == 8'h2a) begin
            used = 1'b1;
            mode_next = ssl_pkg::M_BLOCK;
          end else begin
            pr = push(pr, mk(ssl_pkg::K_TOKEN, ssl_pkg::T_DIV, toff, tline, tcol, tlen));
            mode_next = ssl_pkg::M_IDLE;
          end
        end
        ssl_pkg::M_LINE: begin
          if (char_byte == 8'h0a) begin
            pr = push(pr, mk(ssl_pkg::K_TOKEN, ssl_pkg::T_LINE, toff, tline, tcol, tlen));
            mode_next = ssl_pkg::M_IDLE;
          end else used = 1'b1;
        end
        ssl_pkg::M_BLOCK: begin
          used = 1'b1;
          if (char_byte == 8'h2a) mode_next = ssl_pkg::M_BSTAR;
        end
        ssl_pkg::M_BSTAR: begin
          used = 1'b1;
          if (char_byte == 8'h2f) begin
            pr = push(pr, mk(ssl_pkg::K_TOKEN, ssl_pkg::T_BLOCK, toff, tline, tcol,
                             tlen_inc));
            mode_next = ssl_pkg::M_IDLE;
          end else if (char_byte != 8'h2a) mode_next = ssl_pkg::M_BLOCK;
        end
        ssl_pkg::M_OP: begin
          if (pair_op != 6'd0) begin
            used = 1'b1;
            pr = push(pr, mk(ssl_pkg::K_TOKEN, pair_op, toff, tline, tcol, tlen_inc));
            mode_next = ssl_pkg::M_IDLE;
          end else begin
            pr = push(pr, mk(ssl_pkg::K_TOKEN, ssl_pkg::one_char_op(wbuf[7:0]),
                             toff, tline, tcol, tlen));
            mode_next = ssl_pkg::M_IDLE;
          end
        end
        default: mode_next = ssl_pkg::M_IDLE;
      endcase

      // Advance by one byte inside a token
      if (used && !halted_next) begin
        tlen_next = tlen_inc;
        coff_next = coff_inc;
        ccol_next = ccol_inc;
      end

      // Start a new token or skip whitespace
      if (!used && !halted_next) begin
        if (char_byte == 8'h20 || char_byte == 8'h09 || char_byte == 8'h0d ||
            char_byte == 8'h0a) begin
          if (char_byte == 8'h09) ccol_next = ccol_tab[LINE_BITS] ? '1 : ccol_tab[LINE_BITS-1:0];
          else if (char_byte == 8'h20) ccol_next = ccol_inc;
          else ccol_next = '0;
          if (char_byte == 8'h0a) cline_next = cline_inc;
          coff_next = coff_inc;
        end else if (ssl_pkg::is_letter(char_byte) || ssl_pkg::is_dec(char_byte) ||
                     ssl_pkg::may_pair(char_byte) ||
                     ssl_pkg::one_char_op(char_byte) != 6'd0) begin
          toff_next = coff;
          tline_next = cline;
          tcol_next = ccol;
          tlen_next = {{(LENGTH_BITS - 1){1'b0}}, 1'b1};
          coff_next = coff_inc;
          ccol_next = ccol_inc;
          if (ssl_pkg::is_letter(char_byte)) begin
            mode_next = ssl_pkg::M_IDENT;
            wbuf_next = {56'd0, char_byte};
            wcnt_next = 4'd1;
          end else if (char_byte == 8'h30) mode_next = ssl_pkg::M_ZERO;
          else if (ssl_pkg::is_dec(char_byte)) mode_next = ssl_pkg::M_DEC;
          else if (char_byte == 8'h2f) mode_next = ssl_pkg::M_SLASH;
          else if (ssl_pkg::may_pair(char_byte)) begin
            mode_next = ssl_pkg::M_OP;
            wbuf_next = {56'd0, char_byte};
          end else begin
            mode_next = ssl_pkg::M_IDLE;
            pr = push(pr, mk(ssl_pkg::K_TOKEN, ssl_pkg::one_char_op(char_byte), coff,
                             cline, ccol, {{(LENGTH_BITS - 1){1'b0}}, 1'b1}));
          end
        end else begin
          pr = push(pr, mk(ssl_pkg::K_ERROR, ssl_pkg::T_IDENT, coff, cline, ccol, '0));
          halted_next = 1'b1;
          mode_next = ssl_pkg::M_IDLE;
        end
      end

      // Close whatever is pending on the final byte
      if (last_byte && !halted_next) begin
        case (mode_next)
          ssl_pkg::M_IDENT:
            pr = push(pr, mk(ssl_pkg::K_TOKEN, ssl_pkg::keyword_code(wbuf_next, wcnt_next),
                             toff_next, tline_next, tcol_next, tlen_next));
          ssl_pkg::M_ZERO, ssl_pkg::M_DEC:
            pr = push(pr, mk(ssl_pkg::K_TOKEN, ssl_pkg::T_DEC, toff_next, tline_next,
                             tcol_next, tlen_next));
          ssl_pkg::M_OCT:
            pr = push(pr, mk(ssl_pkg::K_TOKEN, ssl_pkg::T_OCT, toff_next, tline_next,
                             tcol_next, tlen_next));
          ssl_pkg::M_ZX, ssl_pkg::M_HEX:
            pr = push(pr, mk(ssl_pkg::K_TOKEN, ssl_pkg::T_HEX, toff_next, tline_next,
                             tcol_next, tlen_next));
          ssl_pkg::M_ZB, ssl_pkg::M_BIN:
            pr = push(pr, mk(ssl_pkg::K_TOKEN, ssl_pkg::T_BIN, toff_next, tline_next,
                             tcol_next, tlen_next));
          ssl_pkg::M_SLASH:
            pr = push(pr, mk(ssl_pkg::K_TOKEN, ssl_pkg::T_DIV, toff_next, tline_next,
                             tcol_next, tlen_next));
          ssl_pkg::M_LINE:
            pr = push(pr, mk(ssl_pkg::K_TOKEN, ssl_pkg::T_LINE, toff_next, tline_next,
                             tcol_next, tlen_next));
          ssl_pkg::M_BLOCK, ssl_pkg::M_BSTAR:
            pr = push(pr, mk(ssl_pkg::K_ERROR, ssl_pkg::T_IDENT, toff_next, tline_next,
                             tcol_next, '0));
          ssl_pkg::M_OP:
            pr = push(pr, mk(ssl_pkg::K_TOKEN, ssl_pkg::one_char_op(wbuf_next[7:0]),
                             toff_next, tline_next, tcol_next, tlen_next));
          default: pr = pr;
        endcase
      end
    end

    // Mark the end of source and restart positions
    if (last_byte) begin
      if (pr.n == 2'd0) pr = push(pr, mk(ssl_pkg::K_END, ssl_pkg::T_IDENT, coff_next,
                                         cline_next, ccol_next, '0));
      if (pr.n == 2'd1) pr.r0.stream_end = 1'b1;
      else pr.r1.stream_end = 1'b1;
      mode_next = ssl_pkg::M_IDLE;
      wbuf_next = '0;
      wcnt_next = '0;
      toff_next = '0;
      tline_next = '0;
      tcol_next = '0;
      tlen_next = '0;
      coff_next = '0;
      cline_next = '0;
      ccol_next = '0;
      halted_next = 1'b0;
    end
  end

  assign pair_bits = pr;

  // Hold the tab width
  always_ff @(posedge clk) begin
    if (rst) tab_width <= ssl_pkg::TAB_RESET;
    else if (cfg_write_en) tab_width <= cfg_write_data;
  end

  // Advance lexer state on each accepted beat
  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= ssl_pkg::M_IDLE;
      wbuf <= '0;
      wcnt <= '0;
      toff <= '0;
      tline <= '0;
      tcol <= '0;
      tlen <= '0;
      coff <= '0;
      cline <= '0;
      ccol <= '0;
      halted <= 1'b0;
    end else if (accept) begin
      mode <= mode_next;
      wbuf <= wbuf_next;
      wcnt <= wcnt_next;
      toff <= toff_next;
      tline <= tline_next;
      tcol <= tcol_next;
      tlen <= tlen_next;
      coff <= coff_next;
      cline <= cline_next;
      ccol <= ccol_next;
      halted <= halted_next;
    end
  end

endmodule

### hdl/ssl_queue.sv
module ssl_queue #(
  parameter int RES_W   = 89,
  localparam int PAIR_W = 2 + 2 * RES_W
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  logic [PAIR_W-1:0] pair_in,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [RES_W-1:0]  out_data
);

  logic [PAIR_W-1:0] q [2];
  logic              wptr, rptr, sub;
  logic [1:0]        cnt;
  logic [PAIR_W-1:0] head;
  logic              pop, pop_pair, wr;

  assign head      = q[rptr];
  assign in_ready  = cnt != 2'd2;
  assign out_valid = cnt != 2'd0;
  assign out_data  = sub ? head[2*RES_W-1:RES_W] : head[RES_W-1:0];
  assign pop       = out_valid && out_ready;
  assign pop_pair  = pop && (sub || head[PAIR_W-1:PAIR_W-2] != 2'd2);
  assign wr        = push && pair_in[PAIR_W-1:PAIR_W-2] != 2'd0;

  // Store result pairs
  always_ff @(posedge clk) begin
    if (wr) q[wptr] <= pair_in;
  end

  // Advance pointers per beat
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      sub <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (wr) wptr <= ~wptr;
      if (pop_pair) begin
        rptr <= ~rptr;
        sub <= 1'b0;
      end else if (pop) sub <= 1'b1;
      cnt <= cnt + {1'b0, wr} - {1'b0, pop_pair};
    end
  end

endmodule

### hdl/script_source_lexer.sv
// Streaming lexer: takes one source byte per beat and returns tokens (type, start
// offset, line, column, length), error results and end-of-source results. Each byte
// is worked out in the same cycle it is accepted, so one byte per clock is taken
// at full rate; a byte may produce up to two results, which sit in a two-entry
// queue of result pairs and leave one per cycle, so a stalled consumer stops the
// input only once that queue holds two pairs. The user must write the tab width
// register via cfg_write_en/cfg_write_data only while idle; nothing enforces it.
module script_source_lexer #(
  parameter int OFFSET_BITS = 24,
  parameter int LINE_BITS   = 20,
  parameter int LENGTH_BITS = 16
) (
  input  logic       clk,
  input  logic       rst,
  ssl_in_if.sink     in_ch,
  ssl_out_if.source  out_ch,
  input  logic       cfg_write_en,
  input  logic [4:0] cfg_write_data
);

  localparam int RES_W  = 2 + 6 + OFFSET_BITS + 2 * LINE_BITS + LENGTH_BITS + 1;
  localparam int PAIR_W = 2 + 2 * RES_W;

  typedef struct packed {
    logic [1:0]             kind;
    logic [5:0]             tok_code;
    logic [OFFSET_BITS-1:0] start_offset;
    logic [LINE_BITS-1:0]   start_line;
    logic [LINE_BITS-1:0]   start_column;
    logic [LENGTH_BITS-1:0] token_length;
    logic                   stream_end;
  } res_t;

  logic              accept;
  logic [PAIR_W-1:0] pair_bits;
  logic [RES_W-1:0]  head_bits;
  res_t              head;

  assign accept = in_ch.valid && in_ch.ready;

  ssl_core #(
    .OFFSET_BITS(OFFSET_BITS),
    .LINE_BITS(LINE_BITS),
    .LENGTH_BITS(LENGTH_BITS)
  ) u_core (
    .clk(clk),
    .rst(rst),
    .cfg_write_en(cfg_write_en),
    .cfg_write_data(cfg_write_data),
    .accept(accept),
    .char_byte(in_ch.char_byte),
    .last_byte(in_ch.last_byte),
    .pair_bits(pair_bits)
  );

  ssl_queue #(
    .RES_W(RES_W)
  ) u_queue (
    .clk(clk),
    .rst(rst),
    .push(accept),
    .pair_in(pair_bits),
    .in_ready(in_ch.ready),
    .out_valid(out_ch.valid),
    .out_ready(out_ch.ready),
    .out_data(head_bits)
  );

  // Unpack the head result onto the output beat
  assign head                = res_t'(head_bits);
  assign out_ch.kind         = head.kind;
  assign out_ch.tok_code     = head.tok_code;
  assign out_ch.start_offset = head.start_offset;
  assign out_ch.start_line   = head.start_line;
  assign out_ch.start_column = head.start_column;
  assign out_ch.token_length = head.token_length;
  assign out_ch.stream_end   = head.stream_end;

endmodule

### sim/tb.sv
`timescale 1ns / 1ps

module tb;

  localparam int QUIET_LIMIT = 5000;
  localparam int N_RANDOM = 880;

  typedef struct packed {
    logic [1:0]  kind;
    logic [5:0]  tok_code;
    logic [23:0] start_offset;
    logic [19:0] start_line;
    logic [19:0] start_column;
    logic [15:0] token_length;
    logic        stream_end;
  } token_t;

  // directed row: byte, last flag, optional typed expectation of first result
  typedef struct {
    logic [7:0] ch;
    logic       last;
    logic       has_exp;
    token_t     exp;
  } row_t;

  logic clk;
  logic rst;
  logic cfg_write_en;
  logic [4:0] cfg_write_data;

  ssl_in_if in_ch ();
  ssl_out_if #(.OFFSET_BITS(24), .LINE_BITS(20), .LENGTH_BITS(16)) out_ch ();

  script_source_lexer dut (
    .clk(clk), .rst(rst), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_write_en(cfg_write_en), .cfg_write_data(cfg_write_data)
  );

  // lexer shadow state
  logic [4:0]      lx_tab;
  ssl_pkg::mode_t  lx_mode;
  logic [63:0]     lx_word;
  logic [3:0]      lx_wcnt;
  logic [23:0]     lx_toff, lx_coff;
  logic [19:0]     lx_tline, lx_tcol, lx_cline, lx_ccol;
  logic [15:0]     lx_tlen;
  logic            lx_halt;
  token_t          step_res[$];

  token_t pending_tokens[$];
  int errors;
  int quiet;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic logic [23:0] inc_off(logic [23:0] v);
    return (v == 24'hFFFFFF) ? v : v + 1'b1;
  endfunction

  function automatic logic [19:0] add_pos(logic [19:0] v, logic [19:0] a);
    logic [20:0] s;
    s = v + a;
    return s[20] ? 20'hFFFFF : s[19:0];
  endfunction

  function automatic logic [5:0] kw_lookup(logic [63:0] w, logic [3:0] n);
    string kw[15];
    logic [63:0] p;
    kw = '{"if", "else", "for", "let", "const", "Int", "Uint", "Bool", "break",
           "continue", "return", "function", "true", "false", "requires"};
    if (n > 8) return ssl_pkg::T_IDENT;
    for (int k = 0; k < 15; k++) begin
      p = '0;
      for (int i = 0; i < kw[k].len(); i++) p[8*i +: 8] = kw[k][i];
      if (kw[k].len() == n && p == w) return 6'(k + 1);
    end
    return ssl_pkg::T_IDENT;
  endfunction

  function automatic logic [5:0] single_op(logic [7:0] c);
    case (c)
      "(": return 6'd22; ")": return 6'd23; "{": return 6'd24; "}": return 6'd25;
      "=": return 6'd26; "+": return 6'd29; "-": return 6'd30; "*": return 6'd32;
      "/": return 6'd33; "%": return 6'd34; "<": return 6'd35; ">": return 6'd38;
      "&": return 6'd41; "|": return 6'd43; "^": return 6'd45; "~": return 6'd46;
      "!": return 6'd47; ":": return 6'd49; ";": return 6'd50; ".": return 6'd51;
      ",": return 6'd52;
      default: return 6'd0;
    endcase
  endfunction

  function automatic logic [5:0] pair_op(logic [7:0] a, logic [7:0] b);
    case ({a, b})
      "==": return 6'd27; "=>": return 6'd28; "->": return 6'd31; "<<": return 6'd36;
      "<=": return 6'd37; ">>": return 6'd39; ">=": return 6'd40; "&&": return 6'd42;
      "||": return 6'd44; "!=": return 6'd48;
      default: return 6'd0;
    endcase
  endfunction

  function automatic logic letter(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
  endfunction

  function automatic logic digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic hexdig(logic [7:0] c);
    return digit(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
  endfunction

  function automatic logic pairable(logic [7:0] c);
    return c == "=" || c == "-" || c == "<" || c == ">" || c == "&" || c == "|" ||
           c == "!";
  endfunction

  function automatic void push_res(logic [1:0] k, logic [5:0] t, logic [23:0] o,
                                   logic [19:0] l, logic [19:0] c, logic [15:0] n);
    token_t r;
    if (step_res.size() >= 2) return;
    r = '{k, t, o, l, c, n, 1'b0};
    step_res.insert(step_res.size(), r);
  endfunction

  function automatic void close_token(logic [5:0] t);
    push_res(ssl_pkg::K_TOKEN, t, lx_toff, lx_tline, lx_tcol, lx_tlen);
    lx_mode = ssl_pkg::M_IDLE;
  endfunction

  function automatic void raise_error(logic [23:0] o, logic [19:0] l, logic [19:0] c);
    push_res(ssl_pkg::K_ERROR, ssl_pkg::T_IDENT, o, l, c, 16'd0);
    lx_halt = 1'b1;
    lx_mode = ssl_pkg::M_IDLE;
  endfunction

  function automatic void consume();
    lx_tlen = (lx_tlen == 16'hFFFF) ? lx_tlen : lx_tlen + 1'b1;
    lx_coff = inc_off(lx_coff);
    lx_ccol = add_pos(lx_ccol, 20'd1);
  endfunction

  task automatic open_token(ssl_pkg::mode_t m);
    lx_toff = lx_coff;
    lx_tline = lx_cline;
    lx_tcol = lx_ccol;
    lx_tlen = '0;
    consume();
    lx_mode = m;
  endtask

  task automatic clear_source();
    lx_mode = ssl_pkg::M_IDLE;
    lx_word = '0;
    lx_wcnt = '0;
    lx_toff = '0; lx_tline = '0; lx_tcol = '0; lx_tlen = '0;
    lx_coff = '0; lx_cline = '0; lx_ccol = '0;
    lx_halt = 1'b0;
  endtask

  // returns 1 if the byte was absorbed by the pending token or raised an error
  function automatic logic extend_token(logic [7:0] c);
    logic [5:0] p;
    case (lx_mode)
      ssl_pkg::M_IDENT: begin
        if (letter(c) || digit(c)) begin
          if (lx_wcnt < 8) begin
            lx_word[8*lx_wcnt +: 8] = c;
            lx_wcnt++;
          end else begin
            lx_wcnt = 4'd9;
          end
          consume();
          return 1'b1;
        end
        close_token(kw_lookup(lx_word, lx_wcnt));
        return 1'b0;
      end
      ssl_pkg::M_ZERO: begin
        if (c == "x") begin consume(); lx_mode = ssl_pkg::M_ZX; return 1'b1; end
        if (c == "b") begin consume(); lx_mode = ssl_pkg::M_ZB; return 1'b1; end
        if (c >= "0" && c <= "7") begin
          consume();
          lx_mode = ssl_pkg::M_OCT;
          return 1'b1;
        end
        close_token(ssl_pkg::T_OCT);
        return 1'b0;
      end
      ssl_pkg::M_OCT: begin
        if (c >= "0" && c <= "7") begin consume(); return 1'b1; end
        close_token(ssl_pkg::T_OCT);
        return 1'b0;
      end
      ssl_pkg::M_ZX, ssl_pkg::M_ZB: begin
        if (lx_mode == ssl_pkg::M_ZX ? hexdig(c) : (c == "0" || c == "1")) begin
          consume();
          lx_mode = (lx_mode == ssl_pkg::M_ZX) ? ssl_pkg::M_HEX : ssl_pkg::M_BIN;
          return 1'b1;
        end
        raise_error(lx_toff, lx_tline, lx_tcol);
        return 1'b1;
      end
      ssl_pkg::M_HEX: begin
        if (hexdig(c)) begin consume(); return 1'b1; end
        close_token(ssl_pkg::T_HEX);
        return 1'b0;
      end
      ssl_pkg::M_BIN: begin
        if (c == "0" || c == "1") begin consume(); return 1'b1; end
        close_token(ssl_pkg::T_BIN);
        return 1'b0;
      end
      ssl_pkg::M_DEC: begin
        if (digit(c)) begin consume(); return 1'b1; end
        close_token(ssl_pkg::T_DEC);
        return 1'b0;
      end
      ssl_pkg::M_SLASH: begin
        if (c == "/") begin consume(); lx_mode = ssl_pkg::M_LINE; return 1'b1; end
        if (c == "*") begin consume(); lx_mode = ssl_pkg::M_BLOCK; return 1'b1; end
        close_token(ssl_pkg::T_DIV);
        return 1'b0;
      end
      ssl_pkg::M_LINE: begin
        if (c == 8'h0a) begin close_token(ssl_pkg::T_LINE); return 1'b0; end
        consume();
        return 1'b1;
      end
      ssl_pkg::M_BLOCK: begin
        consume();
        if (c == "*") lx_mode = ssl_pkg::M_BSTAR;
        return 1'b1;
      end
      ssl_pkg::M_BSTAR: begin
        consume();
        if (c == "/") close_token(ssl_pkg::T_BLOCK);
        else if (c != "*") lx_mode = ssl_pkg::M_BLOCK;
        return 1'b1;
      end
      ssl_pkg::M_OP: begin
        p = pair_op(lx_word[7:0], c);
        if (p != 0) begin consume(); close_token(p); return 1'b1; end
        close_token(single_op(lx_word[7:0]));
        return 1'b0;
      end
      default: begin
        lx_mode = ssl_pkg::M_IDLE;
        return 1'b0;
      end
    endcase
  endfunction

  task automatic start_token(logic [7:0] c);
    if (c == " " || c == 8'h09 || c == 8'h0d || c == 8'h0a) begin
      if (c == 8'h09) lx_ccol = add_pos(lx_ccol, 20'(lx_tab));
      else if (c == " ") lx_ccol = add_pos(lx_ccol, 20'd1);
      else lx_ccol = '0;
      if (c == 8'h0a) lx_cline = add_pos(lx_cline, 20'd1);
      lx_coff = inc_off(lx_coff);
    end else if (letter(c)) begin
      open_token(ssl_pkg::M_IDENT);
      lx_word = 64'(c);
      lx_wcnt = 4'd1;
    end else if (c == "0") begin
      open_token(ssl_pkg::M_ZERO);
    end else if (digit(c)) begin
      open_token(ssl_pkg::M_DEC);
    end else if (c == "/") begin
      open_token(ssl_pkg::M_SLASH);
    end else if (pairable(c)) begin
      open_token(ssl_pkg::M_OP);
      lx_word = 64'(c);
    end else if (single_op(c) != 0) begin
      open_token(ssl_pkg::M_IDLE);
      close_token(single_op(c));
    end else begin
      raise_error(lx_coff, lx_cline, lx_ccol);
    end
  endtask

  task automatic flush_at_end();
    case (lx_mode)
      ssl_pkg::M_IDENT: close_token(kw_lookup(lx_word, lx_wcnt));
      ssl_pkg::M_ZERO: close_token(ssl_pkg::T_DEC);
      ssl_pkg::M_OCT: close_token(ssl_pkg::T_OCT);
      ssl_pkg::M_ZX, ssl_pkg::M_HEX: close_token(ssl_pkg::T_HEX);
      ssl_pkg::M_ZB, ssl_pkg::M_BIN: close_token(ssl_pkg::T_BIN);
      ssl_pkg::M_DEC: close_token(ssl_pkg::T_DEC);
      ssl_pkg::M_SLASH: close_token(ssl_pkg::T_DIV);
      ssl_pkg::M_LINE: close_token(ssl_pkg::T_LINE);
      ssl_pkg::M_BLOCK, ssl_pkg::M_BSTAR: raise_error(lx_toff, lx_tline, lx_tcol);
      ssl_pkg::M_OP: close_token(single_op(lx_word[7:0]));
      default: ;
    endcase
  endtask

  // compute results of one byte into step_res
  task automatic lex_byte(logic [7:0] c, logic last);
    step_res.delete();
    if (!lx_halt) begin
      if (lx_mode == ssl_pkg::M_IDLE || !extend_token(c)) begin
        if (!lx_halt) start_token(c);
      end
      if (last && !lx_halt) flush_at_end();
    end
    if (last) begin
      if (step_res.size() == 0)
        push_res(ssl_pkg::K_END, ssl_pkg::T_IDENT, lx_coff, lx_cline, lx_ccol, 16'd0);
      step_res[step_res.size() - 1].stream_end = 1'b1;
      clear_source();
    end
  endtask

  // drive one beat with a random gap; predict its results
  task automatic send_byte(logic [7:0] c, logic last, logic has_exp, token_t exp);
    int gap;
    gap = (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8));
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.char_byte <= c;
    in_ch.last_byte <= last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    lex_byte(c, last);
    if (has_exp && step_res[0] !== exp) begin
      $display("%0t: typed expectation %p differs from prediction %p", $time, exp,
               step_res[0]);
      errors++;
    end
    foreach (step_res[i]) pending_tokens.insert(pending_tokens.size(), step_res[i]);
  endtask

  task automatic send_text(string s, logic end_it);
    for (int i = 0; i < s.len(); i++)
      send_byte(s[i], end_it && i == s.len() - 1, 1'b0, '0);
  endtask

  task automatic drain_then_write(logic [4:0] v);
    in_ch.valid <= 1'b0;
    while (pending_tokens.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_write_en <= 1'b1;
    cfg_write_data <= v;
    @(posedge clk);
    cfg_write_en <= 1'b0;
    lx_tab = v;
  endtask

  function automatic logic [7:0] pick_byte();
    string alpha;
    alpha = "abcefilnorstuxABFIU_0123456789 \t\r\n/*(){}=+-%<>&|^~!:;.,";
    case ($urandom_range(0, 19))
      0: return 8'($urandom_range(0, 255));
      default: return alpha[$urandom_range(0, alpha.len() - 1)];
    endcase
  endfunction

  function automatic string pick_word();
    string w[24];
    w = '{"if", "else", "for", "let", "const", "Int", "Uint", "Bool", "break",
          "continue", "return", "function", "true", "false", "requires", "while",
          "0x1F", "0b101", "0777", "42", "// c\n", "/* b */", "->", "!="};
    return w[$urandom_range(0, 23)];
  endfunction

  // output side: random stall, compare each beat with the oldest prediction
  initial begin
    token_t got;
    int stall;
    out_ch.ready = 1'b0;
    @(negedge rst);
    forever begin
      stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
      got = '{out_ch.kind, out_ch.tok_code, out_ch.start_offset, out_ch.start_line,
              out_ch.start_column, out_ch.token_length, out_ch.stream_end};
      if (pending_tokens.size() == 0) begin
        $display("%0t: unexpected result %p", $time, got);
        errors++;
      end else if (got !== pending_tokens[0]) begin
        $display("%0t: expected %p actual %p", $time, pending_tokens[0], got);
        errors++;
        void'(pending_tokens.pop_front());
      end else begin
        void'(pending_tokens.pop_front());
      end
    end
  end

  // watchdog on cycles with no handshake
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= QUIET_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    row_t rows[6];
    logic [4:0] tabs[5];
    string s;
    int n;
    errors = 0;
    quiet = 0;
    rst = 1'b1;
    cfg_write_en = 1'b0;
    cfg_write_data = '0;
    in_ch.valid = 1'b0;
    in_ch.char_byte = '0;
    in_ch.last_byte = 1'b0;
    lx_tab = ssl_pkg::TAB_RESET;
    clear_source();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: rows with typed expectations
    rows[0] = '{8'h00, 1'b1, 1'b1, '{ssl_pkg::K_ERROR, ssl_pkg::T_IDENT, 24'd0, 20'd0,
                                     20'd0, 16'd0, 1'b1}};
    rows[1] = '{8'h20, 1'b1, 1'b1, '{ssl_pkg::K_END, ssl_pkg::T_IDENT, 24'd1, 20'd0,
                                     20'd1, 16'd0, 1'b1}};
    rows[2] = '{8'hFF, 1'b1, 1'b1, '{ssl_pkg::K_ERROR, ssl_pkg::T_IDENT, 24'd0, 20'd0,
                                     20'd0, 16'd0, 1'b1}};
    rows[3] = '{"<", 1'b1, 1'b1, '{ssl_pkg::K_TOKEN, 6'd35, 24'd0, 20'd0, 20'd0, 16'd1,
                                   1'b1}};
    rows[4] = '{"0", 1'b1, 1'b1, '{ssl_pkg::K_TOKEN, ssl_pkg::T_DEC, 24'd0, 20'd0, 20'd0,
                                   16'd1, 1'b1}};
    rows[5] = '{8'h09, 1'b1, 1'b1, '{ssl_pkg::K_END, ssl_pkg::T_IDENT, 24'd1, 20'd0,
                                     20'd4, 16'd0, 1'b1}};
    foreach (rows[i]) send_byte(rows[i].ch, rows[i].last, rows[i].has_exp, rows[i].exp);
    // directed: special cases checked against the prediction
    send_text("0 0x", 1'b1);
    send_text("0bz", 1'b1);
    send_text("/* open", 1'b1);
    send_text("a\t\tcontinue while(x>=1)&&y->z", 1'b1);
    send_text("0x 1;\r\nabcdefghijk 09", 1'b1);

    // sweep the tab width, extremes included
    tabs = '{5'd0, 5'd31, 5'd1, 5'd16, 5'd7};
    foreach (tabs[t]) begin
      drain_then_write(tabs[t]);
      n = 0;
      while (n < N_RANDOM / 5) begin
        if ($urandom_range(0, 2) == 0) begin
          send_byte(pick_byte(), $urandom_range(0, 40) == 0, 1'b0, '0);
          n++;
        end else begin
          s = pick_word();
          send_text(s, 1'b0);
          n += s.len();
          send_byte(($urandom_range(0, 1) == 0) ? " " : 8'h09, $urandom_range(0, 15) == 0,
                    1'b0, '0);
          n++;
        end
      end
      send_byte(8'h0a, 1'b1, 1'b0, '0);
    end

    in_ch.valid <= 1'b0;
    while (pending_tokens.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
